FILE: rtl/bzs_pkg.sv
// ----------------------------------------------------------------------------
// bzs_pkg: shared types and constants of the cubic Bezier segment sampler
// Coordinate, weight and product widths, and the control bundle that steps
// the blend pipeline.
// ----------------------------------------------------------------------------
package bzs_pkg;

    localparam int COORD_W  = 32;   // Q16.16 coordinate
    localparam int FRAC_W   = 16;   // fraction bits of a Q1.16 weight
    localparam int WEIGHT_W = 17;   // Q1.16 weight, 0 .. 1.0 inclusive
    localparam int PROD_W   = 49;   // weight * coordinate, signed
    localparam int ACC_W    = 50;   // sum of four products, signed
    localparam int INDEX_W  = 6;    // sample_index field
    localparam int POINTS   = 8;    // coordinates in one segment

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [WEIGHT_W-1:0] weight_t;

    // Bernstein weights of one sample, w0 on the start anchor
    typedef struct packed {
        weight_t w3;
        weight_t w2;
        weight_t w1;
        weight_t w0;
    } weight_set_t;

    // Load strobes for the two register stages of the blend pipeline
    typedef struct packed {
        logic load_prod;
        logic load_out;
    } blend_ctl_t;

endpackage

FILE: rtl/bzs_weight_rom.sv
// ----------------------------------------------------------------------------
// bzs_weight_rom: Bernstein weight table
// Q1.16 weights for every sample of a segment, built at elaboration from
// rounded cumulative sums so the four weights always add up to exactly 1.0.
// ----------------------------------------------------------------------------
module bzs_weight_rom #(
    parameter int SAMPLES_N = 32,
    parameter int IDX_W     = 5
) (
    input  logic [IDX_W-1:0]        idx,
    output bzs_pkg::weight_set_t    weights
);

    localparam logic [63:0] N    = 64'(SAMPLES_N - 1);
    localparam logic [63:0] N3   = N * N * N;
    localparam logic [63:0] HALF = N3 / 2;
    localparam logic [63:0] ONE  = 64'd1 << bzs_pkg::FRAC_W;

    bzs_pkg::weight_set_t rom_w [SAMPLES_N];

    for (genvar p = 0; p < SAMPLES_N; p++) begin : g_entry
        localparam logic [63:0] P   = 64'(p);
        localparam logic [63:0] Q   = N - P;
        localparam logic [63:0] A   = Q * Q * Q;
        localparam logic [63:0] AB  = A + 64'd3 * Q * Q * P;
        localparam logic [63:0] ABC = AB + 64'd3 * Q * P * P;
        localparam logic [63:0] R1  = (A * ONE + HALF) / N3;
        localparam logic [63:0] R2  = (AB * ONE + HALF) / N3;
        localparam logic [63:0] R3  = (ABC * ONE + HALF) / N3;
        localparam logic [63:0] W1  = R2 - R1;
        localparam logic [63:0] W2  = R3 - R2;
        localparam logic [63:0] W3  = ONE - R3;

        assign rom_w[p].w0 = R1[bzs_pkg::WEIGHT_W-1:0];
        assign rom_w[p].w1 = W1[bzs_pkg::WEIGHT_W-1:0];
        assign rom_w[p].w2 = W2[bzs_pkg::WEIGHT_W-1:0];
        assign rom_w[p].w3 = W3[bzs_pkg::WEIGHT_W-1:0];
    end

    assign weights = rom_w[idx];

endmodule

FILE: rtl/bzs_blend.sv
// ----------------------------------------------------------------------------
// bzs_blend: weighted sum of one coordinate
// Four weight-by-coordinate products into a register, then a sum rounded
// to nearest (ties up) back to Q16.16 into the result register.
// ----------------------------------------------------------------------------
module bzs_blend (
    input  logic                    aclk,
    input  bzs_pkg::blend_ctl_t     ctl,
    input  bzs_pkg::weight_set_t    weights,
    input  bzs_pkg::coord_t         c0,
    input  bzs_pkg::coord_t         c1,
    input  bzs_pkg::coord_t         c2,
    input  bzs_pkg::coord_t         c3,
    output bzs_pkg::coord_t         point
);

    localparam int PW = bzs_pkg::PROD_W;
    localparam int AW = bzs_pkg::ACC_W;

    logic signed [AW-1:0] full0, full1, full2, full3;
    logic signed [PW-1:0] prod0_reg, prod1_reg, prod2_reg, prod3_reg;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] rnd;
    bzs_pkg::coord_t      point_reg;
    bzs_pkg::coord_t      point_next;

    // Weights are unsigned, so a zero sign bit goes in front
    assign full0 = $signed({1'b0, weights.w0}) * c0;
    assign full1 = $signed({1'b0, weights.w1}) * c1;
    assign full2 = $signed({1'b0, weights.w2}) * c2;
    assign full3 = $signed({1'b0, weights.w3}) * c3;

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            prod0_reg <= full0[PW-1:0];
            prod1_reg <= full1[PW-1:0];
            prod2_reg <= full2[PW-1:0];
            prod3_reg <= full3[PW-1:0];
        end
    end

    // Convex weights keep |acc| at most 2^47, so no overflow anywhere
    assign acc = AW'(prod0_reg) + AW'(prod1_reg) + AW'(prod2_reg) + AW'(prod3_reg);
    assign rnd = acc + AW'(1 << (bzs_pkg::FRAC_W - 1));
    assign point_next = rnd[bzs_pkg::FRAC_W +: bzs_pkg::COORD_W];

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

FILE: rtl/cubic_bezier_segment_sampler.sv
// ----------------------------------------------------------------------------
// cubic_bezier_segment_sampler: evenly spaced points on a cubic Bezier
// One segment beat in, SAMPLES point beats out, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat carries a whole segment (start anchor, two control
//   handles, end anchor, each x/y in Q16.16).
//   m_ channel: SAMPLES beats per segment (SAMPLES held to 2..64), point p at
//   t = p/(SAMPLES-1), with its index in tdata and tlast on the final point.
// Path: the segment beat is registered, then weight lookup and products fill
//   the product register, then sum and rounding fill the output register.
// Throughput: one point per cycle unless m_tready stalls, set by the
//   sample counter walking the weight table; the next segment is taken in the
//   cycle that issues the last point, so segments follow without a gap.
// Reset: aresetn low on a clock edge empties the pipeline and idles the
//   counter; no beat is produced while it is held, and a beat taken is dropped.
// Stall: when m_tready is low the output register holds its beat and full
//   stages behind it freeze; s_tready stays low until the last point issues.
// ----------------------------------------------------------------------------
module cubic_bezier_segment_sampler #(
    parameter int SAMPLES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] start_x, [63:32] start_y, [95:64] ctrl1_x, [127:96] ctrl1_y,
    // [159:128] ctrl2_x, [191:160] ctrl2_y, [223:192] end_x, [255:224] end_y
    input  logic [255:0] s_tdata,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] point_x, [63:32] point_y, [69:64] sample_index, [71:70] zero
    output logic [71:0]  m_tdata,
    output logic         m_tlast          // last_sample
);

    // Sample count held to the supported range
    localparam int SAMPLES_N = (SAMPLES < 2) ? 2 : ((SAMPLES > 64) ? 64 : SAMPLES);
    localparam int IDX_W     = $clog2(SAMPLES_N);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_N - 1);
    localparam int CW        = bzs_pkg::COORD_W;

    // Segment register and sample counter
    bzs_pkg::coord_t   seg_reg [bzs_pkg::POINTS];
    logic              busy_reg, busy_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;

    // Product stage tags
    logic              b_valid_reg, b_valid_next;
    logic [IDX_W-1:0]  b_idx_reg;
    logic              b_last_reg;

    // Output stage tags
    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  m_idx_reg;
    logic              m_last_reg;

    logic              out_free;      // output register can take a beat
    logic              b_free;        // product stage can take a sample
    logic              issue;         // a sample enters the product stage
    logic              is_last;
    logic              accept;

    bzs_pkg::weight_set_t weights;
    bzs_pkg::blend_ctl_t  ctl;
    bzs_pkg::coord_t      point_x, point_y;

    // ---------------- flow control ----------------
    always_comb begin
        out_free = !m_valid_reg || m_tready;
        b_free   = !b_valid_reg || out_free;
        issue    = busy_reg && b_free;
        is_last  = (cnt_reg == LAST_IDX);
        s_tready = !busy_reg || (issue && is_last);
        accept   = s_tvalid && s_tready;
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (issue) begin
            cnt_next = is_last ? '0 : cnt_reg + 1'b1;
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
        if (accept) begin
            busy_next = 1'b1;
        end
        b_valid_next = b_free ? issue : b_valid_reg;
        m_valid_next = out_free ? b_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < bzs_pkg::POINTS; i++) begin
                seg_reg[i] <= s_tdata[i*CW +: CW];
            end
        end
        if (issue) begin
            b_idx_reg  <= cnt_reg;
            b_last_reg <= is_last;
        end
        if (ctl.load_out) begin
            m_idx_reg  <= b_idx_reg;
            m_last_reg <= b_last_reg;
        end
    end

    // ---------------- datapath ----------------
    assign ctl.load_prod = issue;
    assign ctl.load_out  = out_free && b_valid_reg;

    bzs_weight_rom #(
        .SAMPLES_N (SAMPLES_N),
        .IDX_W     (IDX_W)
    ) u_rom (
        .idx     (cnt_reg),
        .weights (weights)
    );

    // x coordinates sit at even places of the segment, y at odd
    bzs_blend u_blend_x (
        .aclk    (aclk),
        .ctl     (ctl),
        .weights (weights),
        .c0      (seg_reg[0]),
        .c1      (seg_reg[2]),
        .c2      (seg_reg[4]),
        .c3      (seg_reg[6]),
        .point   (point_x)
    );

    bzs_blend u_blend_y (
        .aclk    (aclk),
        .ctl     (ctl),
        .weights (weights),
        .c0      (seg_reg[1]),
        .c1      (seg_reg[3]),
        .c2      (seg_reg[5]),
        .c3      (seg_reg[7]),
        .point   (point_y)
    );

    // ---------------- result channel ----------------
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, bzs_pkg::INDEX_W'(m_idx_reg), point_y, point_x};

endmodule
